/* design/block_occupancy_mask_defines.svh */
// Assertion macros shared by the block_occupancy_mask design files.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BLOCK_OCCUPANCY_MASK_DEFINES_SVH
`define BLOCK_OCCUPANCY_MASK_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define BOM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("block_occupancy_mask assertion failed");

// Antecedent implies consequent in the next cycle.
`define BOM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("block_occupancy_mask assertion failed");

`endif

/* design/bom_pkg.sv */
// Shared types and constants of the block occupancy mask.
// No dependencies; every other design file but block_occupancy_mask_defines.svh imports this package.
package bom_pkg;

	localparam int CFG_W      = 12;
	localparam int GRID_CFG_W = 7;
	localparam int COUNT_W    = 23;
	localparam int GRID_W     = 6;
	localparam int PIX_W      = 8;
	localparam int OQ_DEPTH   = 3;
	localparam int OQ_CNT_W   = 2;
	localparam int OQ_PTR_W   = 2;
	localparam int APB_AW     = 5;
	localparam int APB_DW     = 32;

	localparam logic [PIX_W-1:0]   WHITE_LEVEL = 8'd128;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

	localparam logic [CFG_W-1:0]      RST_IMAGE_WIDTH   = 12'd2048;
	localparam logic [CFG_W-1:0]      RST_IMAGE_HEIGHT  = 12'd2048;
	localparam logic [CFG_W-1:0]      RST_BLOCK_WIDTH   = 12'd85;
	localparam logic [CFG_W-1:0]      RST_BLOCK_HEIGHT  = 12'd85;
	localparam logic [GRID_CFG_W-1:0] RST_BLOCKS_ACROSS = 7'd24;
	localparam logic [GRID_CFG_W-1:0] RST_BLOCKS_DOWN   = 7'd24;
	localparam logic [COUNT_W-1:0]    RST_THRESHOLD     = 23'd10;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_IMAGE_HEIGHT    = 3'd1,
		REG_BLOCK_WIDTH     = 3'd2,
		REG_BLOCK_HEIGHT    = 3'd3,
		REG_BLOCKS_ACROSS   = 3'd4,
		REG_BLOCKS_DOWN     = 3'd5,
		REG_COUNT_THRESHOLD = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0]      image_width;
		logic [CFG_W-1:0]      image_height;
		logic [CFG_W-1:0]      block_width;
		logic [CFG_W-1:0]      block_height;
		logic [GRID_CFG_W-1:0] blocks_across;
		logic [GRID_CFG_W-1:0] blocks_down;
		logic [COUNT_W-1:0]    count_threshold;
	} cfg_t;

	// Block-end information worked out when a pixel is accepted.
	typedef struct packed {
		logic              report;
		logic [GRID_W-1:0] grid_row;
		logic [GRID_W-1:0] grid_col;
		logic              frame_done;
	} rep_t;

	typedef struct packed {
		logic [GRID_W-1:0] grid_row;
		logic [GRID_W-1:0] grid_col;
		logic              occupied;
		logic              frame_done;
	} res_t;

endpackage

/* design/bom_if.sv */
// Stream interfaces of the block occupancy mask: pixel requests in, block results out.
// Depends on bom_pkg for field widths.
interface bom_pix_if import bom_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             frame_start;

	modport source (output valid, pixel_value, frame_start, input ready);
	modport sink (input valid, pixel_value, frame_start, output ready);
endinterface

interface bom_res_if import bom_pkg::*;;
	logic              valid;
	logic              ready;
	logic [GRID_W-1:0] grid_row;
	logic [GRID_W-1:0] grid_col;
	logic              occupied;
	logic              frame_done;

	modport source (output valid, grid_row, grid_col, occupied, frame_done, input ready);
	modport sink (input valid, grid_row, grid_col, occupied, frame_done, output ready);
endinterface

/* design/bom_position.sv */
// Raster position tracker: pixel, in-block and block grid counters.
// Depends on bom_pkg (cfg_t, rep_t).
module bom_position import bom_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_BLOCKS = 64,
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int COL_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             advance,
	input  logic             frame_start,
	output logic [COL_W-1:0] col_idx,
	output rep_t             rep
);

	logic [XW-1:0]    pixel_x_q, x_in_block_q, px, xb;
	logic [YW-1:0]    pixel_y_q, y_in_block_q, py, yb;
	logic [COL_W-1:0] block_col_q, block_row_q, col, row;
	logic [31:0]      w32, h32, col32, row32;
	logic             row_end, img_end, col_last, row_last, blk_col_end, blk_row_end;

	always_comb begin
		// frame start restarts the position before this pixel is placed
		px  = frame_start ? '0 : pixel_x_q;
		py  = frame_start ? '0 : pixel_y_q;
		xb  = frame_start ? '0 : x_in_block_q;
		yb  = frame_start ? '0 : y_in_block_q;
		col = frame_start ? '0 : block_col_q;
		row = frame_start ? '0 : block_row_q;

		w32 = (cfg.image_width == '0 || 32'(cfg.image_width) > 32'(MAX_WIDTH)) ?
			32'(MAX_WIDTH) : 32'(cfg.image_width);
		h32 = (cfg.image_height == '0 || 32'(cfg.image_height) > 32'(MAX_HEIGHT)) ?
			32'(MAX_HEIGHT) : 32'(cfg.image_height);
		col32 = 32'(col);
		row32 = 32'(row);

		row_end  = (32'(px) + 32'd1) >= w32;
		img_end  = (32'(py) + 32'd1) >= h32;
		col_last = (col32 + 32'd1 == 32'(cfg.blocks_across)) || (col32 >= 32'(MAX_BLOCKS - 1));
		row_last = (row32 + 32'd1 == 32'(cfg.blocks_down)) || (row32 >= 32'(MAX_BLOCKS - 1));
		blk_col_end = row_end || (!col_last && (32'(xb) + 32'd1 == 32'(cfg.block_width)));
		blk_row_end = img_end || (!row_last && (32'(yb) + 32'd1 == 32'(cfg.block_height)));

		rep.report     = blk_col_end && blk_row_end;
		rep.grid_row   = row32[GRID_W-1:0];
		rep.grid_col   = col32[GRID_W-1:0];
		rep.frame_done = row_end && img_end;
	end

	assign col_idx = col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_x_q    <= '0;
			pixel_y_q    <= '0;
			x_in_block_q <= '0;
			y_in_block_q <= '0;
			block_col_q  <= '0;
			block_row_q  <= '0;
		end else if (advance) begin
			if (row_end) begin
				pixel_x_q    <= '0;
				x_in_block_q <= '0;
				block_col_q  <= '0;
				if (img_end) begin
					pixel_y_q    <= '0;
					y_in_block_q <= '0;
					block_row_q  <= '0;
				end else begin
					pixel_y_q <= py + YW'(1);
					if (blk_row_end) begin
						y_in_block_q <= '0;
						block_row_q  <= row + COL_W'(1);
					end else begin
						y_in_block_q <= yb + YW'(1);
						block_row_q  <= row;
					end
				end
			end else begin
				pixel_x_q    <= px + XW'(1);
				pixel_y_q    <= py;
				y_in_block_q <= yb;
				block_row_q  <= row;
				if (blk_col_end) begin
					x_in_block_q <= '0;
					block_col_q  <= col + COL_W'(1);
				end else begin
					x_in_block_q <= xb + XW'(1);
					block_col_q  <= col;
				end
			end
		end
	end

endmodule

/* design/bom_count_unit.sv */
// Per-column white count memory with read-modify-write, forwarding and valid bits.
// Depends on bom_pkg and block_occupancy_mask_defines.svh.
`include "block_occupancy_mask_defines.svh"

module bom_count_unit import bom_pkg::*; #(
	parameter int MAX_BLOCKS = 64,
	localparam int COL_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               issue,
	input  logic               frame_start,
	input  logic [PIX_W-1:0]   pixel_value,
	input  logic [COL_W-1:0]   col_idx,
	input  rep_t               rep,
	input  logic [COUNT_W-1:0] threshold,
	output logic               busy,
	output logic               res_valid,
	output res_t               res
);

	logic [COUNT_W-1:0]    mem [MAX_BLOCKS];
	logic [COUNT_W-1:0]    rdata_s1, wb_q, base, new_cnt, wr_data;
	logic [COL_W-1:0]      col_s1;
	logic                  white_s1, v_s1, fs_s1, fwd_s1;
	rep_t                  rep_s1;
	logic [MAX_BLOCKS-1:0] valid_q;

	// read at accept, write back in the next cycle
	always_ff @(posedge clk) begin
		if (issue) begin
			rdata_s1 <= mem[col_idx];
		end
		if (v_s1) begin
			mem[col_s1] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			col_s1   <= col_idx;
			white_s1 <= pixel_value > WHITE_LEVEL;
			rep_s1   <= rep;
		end
		if (v_s1) begin
			wb_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			fs_s1   <= 1'b0;
			fwd_s1  <= 1'b0;
			valid_q <= '0;
		end else begin
			v_s1   <= issue;
			fs_s1  <= issue && frame_start;
			// the entry being written now is stale in the memory read
			fwd_s1 <= issue && v_s1 && (col_idx == col_s1);
			if (issue && frame_start) begin
				valid_q <= '0;
			end else if (v_s1) begin
				valid_q[col_s1] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (fs_s1) begin
			base = '0;
		end else if (fwd_s1) begin
			base = wb_q;
		end else if (valid_q[col_s1]) begin
			base = rdata_s1;
		end else begin
			base = '0;
		end
		new_cnt = (white_s1 && base != COUNT_MAX) ? base + COUNT_W'(1) : base;
		// drop the count once its block is reported
		wr_data = rep_s1.report ? '0 : new_cnt;
	end

	assign busy           = v_s1;
	assign res_valid      = v_s1 && rep_s1.report;
	assign res.grid_row   = rep_s1.grid_row;
	assign res.grid_col   = rep_s1.grid_col;
	assign res.occupied   = new_cnt > threshold;
	assign res.frame_done = rep_s1.frame_done;

	`BOM_ASSERT_IMP(a_fwd_back_to_back, fwd_s1, v_s1 && $past(v_s1))
	`BOM_ASSERT_NXT(a_report_clears, v_s1 && rep_s1.report, wb_q == '0)
	`BOM_ASSERT_IMP(a_count_no_wrap, v_s1, new_cnt >= base)

endmodule

/* design/bom_out_queue.sv */
// Three-entry result queue that decouples the count pipeline from the result sink.
// Depends on bom_pkg, bom_res_if and block_occupancy_mask_defines.svh.
`include "block_occupancy_mask_defines.svh"

module bom_out_queue import bom_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  res_t                push_data,
	output logic [OQ_CNT_W-1:0] occ,
	bom_res_if.source           res_out
);

	res_t                entry_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_CNT_W-1:0] occ_q;
	logic                pop;

	assign pop = res_out.valid && res_out.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_ptr_q + OQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_ptr_q + OQ_PTR_W'(1);
			end
			occ_q <= occ_q + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
		end
	end

	assign occ                = occ_q;
	assign res_out.valid      = occ_q != '0;
	assign res_out.grid_row   = entry_q[rd_ptr_q].grid_row;
	assign res_out.grid_col   = entry_q[rd_ptr_q].grid_col;
	assign res_out.occupied   = entry_q[rd_ptr_q].occupied;
	assign res_out.frame_done = entry_q[rd_ptr_q].frame_done;

	`BOM_ASSERT_IMP(a_no_push_full, push, occ_q < OQ_CNT_W'(OQ_DEPTH))
	`BOM_ASSERT_NXT(a_occ_hold, !push && !pop, $stable(occ_q))

endmodule

/* design/block_occupancy_mask.sv */
// Top level of the block occupancy mask: APB register file, position tracker,
// count memory pipeline and result queue. Depends on bom_pkg, bom_if and the bom_* modules.
//
// Grayscale pixels arrive in raster order on pix_in, one request per clock while ready;
// a pixel whose value is above 128 counts as white. The frame is split into a grid of
// blocks_across by blocks_down blocks of block_width by block_height pixels, the last
// column and row reaching to the image edge. One running white count per block column
// lives in a MAX_BLOCKS-entry synchronous memory: the entry is read when the pixel is
// accepted and written back in the next cycle, and a pixel that hits the column just
// written takes the fresh value by forwarding. A frame_start request clears all counts
// at once through a valid bit per entry, so no clearing pass is needed. On the last pixel
// of a block one result request carries the block's grid position, whether its count
// exceeds count_threshold and, for the final block, frame_done. A result is formed
// in the write-back stage and registered into the result queue, which presents it
// on res_out. A three-entry result queue absorbs a
// stalled sink, and pix_in.ready drops only when that queue together with the pixel in
// the write-back stage could overflow it. Registers are written over APB at byte address
// 4*index and should only change while the block is idle.
module block_occupancy_mask import bom_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048,
	parameter int MAX_BLOCKS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	bom_pix_if.sink           pix_in,
	bom_res_if.source         res_out
);

	localparam int COL_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

	cfg_t                cfg_q;
	reg_idx_t            reg_idx;
	logic                cfg_wr;
	logic                accept;
	logic [COL_W-1:0]    col_idx;
	rep_t                rep;
	logic                busy;
	logic                res_valid;
	res_t                res;
	logic [OQ_CNT_W-1:0] occ;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width     <= RST_IMAGE_WIDTH;
			cfg_q.image_height    <= RST_IMAGE_HEIGHT;
			cfg_q.block_width     <= RST_BLOCK_WIDTH;
			cfg_q.block_height    <= RST_BLOCK_HEIGHT;
			cfg_q.blocks_across   <= RST_BLOCKS_ACROSS;
			cfg_q.blocks_down     <= RST_BLOCKS_DOWN;
			cfg_q.count_threshold <= RST_THRESHOLD;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IMAGE_WIDTH:     cfg_q.image_width     <= pwdata[CFG_W-1:0];
				REG_IMAGE_HEIGHT:    cfg_q.image_height    <= pwdata[CFG_W-1:0];
				REG_BLOCK_WIDTH:     cfg_q.block_width     <= pwdata[CFG_W-1:0];
				REG_BLOCK_HEIGHT:    cfg_q.block_height    <= pwdata[CFG_W-1:0];
				REG_BLOCKS_ACROSS:   cfg_q.blocks_across   <= pwdata[GRID_CFG_W-1:0];
				REG_BLOCKS_DOWN:     cfg_q.blocks_down     <= pwdata[GRID_CFG_W-1:0];
				REG_COUNT_THRESHOLD: cfg_q.count_threshold <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IMAGE_WIDTH:     prdata = APB_DW'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:    prdata = APB_DW'(cfg_q.image_height);
			REG_BLOCK_WIDTH:     prdata = APB_DW'(cfg_q.block_width);
			REG_BLOCK_HEIGHT:    prdata = APB_DW'(cfg_q.block_height);
			REG_BLOCKS_ACROSS:   prdata = APB_DW'(cfg_q.blocks_across);
			REG_BLOCKS_DOWN:     prdata = APB_DW'(cfg_q.blocks_down);
			REG_COUNT_THRESHOLD: prdata = APB_DW'(cfg_q.count_threshold);
			default:             prdata = '0;
		endcase
	end

	// hold off pixels when the queue plus the write-back stage could fill it
	assign pix_in.ready = ({1'b0, occ} + {2'b00, busy}) < 3'(OQ_DEPTH);
	assign accept       = pix_in.valid && pix_in.ready;

	bom_position #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_position (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.advance     (accept),
		.frame_start (pix_in.frame_start),
		.col_idx     (col_idx),
		.rep         (rep)
	);

	bom_count_unit #(
		.MAX_BLOCKS (MAX_BLOCKS)
	) u_count (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (accept),
		.frame_start (pix_in.frame_start),
		.pixel_value (pix_in.pixel_value),
		.col_idx     (col_idx),
		.rep         (rep),
		.threshold   (cfg_q.count_threshold),
		.busy        (busy),
		.res_valid   (res_valid),
		.res         (res)
	);

	bom_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.occ       (occ),
		.res_out   (res_out)
	);

endmodule

/* dv/tb_block_occupancy_mask.sv */
// Self-checking testbench for block_occupancy_mask: pixel requests in, block results out,
// registers over APB, each result checked against a bench block-count tracker or a typed result.
// Depends on bom_pkg, bom_if and the design files of block_occupancy_mask.
module tb_block_occupancy_mask;
	import bom_pkg::*;

	localparam int MAX_WIDTH      = 2048;
	localparam int MAX_HEIGHT     = 2048;
	localparam int MAX_BLOCKS     = 64;
	localparam int SETTLE_CYCLES  = 6;     // a result passes the write-back stage and the result queue before it leaves
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with no request moving on any port
	localparam int RANDOM_ITEMS   = 350;
	localparam int DIR_ROWS       = 27;
	localparam res_t NO_RES       = '0;

	// Kinds of rows in the directed table.
	typedef enum {ROW_CFG, ROW_TYPED, ROW_NONE, ROW_PREDICT} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		int                arg;     // config table index for ROW_CFG
		logic [PIX_W-1:0]  pix;
		logic              fs;
		res_t              want;    // typed result for ROW_TYPED
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	bom_pix_if pix_if ();
	bom_res_if res_if ();

	block_occupancy_mask #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_BLOCKS (MAX_BLOCKS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (pix_if),
		.res_out (res_if)
	);

	// Register shadow and tracker state: raster position, block position and one
	// white count per block column.
	cfg_t shadow_cfg;
	int   pos_x, pos_y, x_blk, y_blk, cur_col, cur_row;
	int   col_counts [MAX_BLOCKS];

	res_t pending_blocks [$];   // block results still owed by the block, oldest first
	res_t oldest_block;
	int   mismatches;
	int   idle_run;
	bit   sender_quiet;         // no gaps between pixel requests while set

	cfg_t     dir_cfgs [4];
	dir_row_t dir_rows [DIR_ROWS];

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Gap lengths: mostly none, some short, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Lean on the white threshold: values right at and just above it show up often.
	function automatic logic [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd128;
			1: return 8'd129;
			2: return 8'd0;
			3: return 8'd255;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Out-of-range image sizes fall back to the maximum.
	function automatic int fit_size(logic [CFG_W-1:0] v, int maxv);
		return (v == '0 || int'(v) > maxv) ? maxv : int'(v);
	endfunction

	// The top grid index is always the last one, whatever the count says.
	function automatic bit last_index(int idx, logic [GRID_CFG_W-1:0] count);
		return (idx + 1 == int'(count)) || (idx >= MAX_BLOCKS - 1);
	endfunction

	function automatic logic [APB_DW-1:0] reg_value(cfg_t c, reg_idx_t idx);
		case (idx)
			REG_IMAGE_WIDTH:   return APB_DW'(c.image_width);
			REG_IMAGE_HEIGHT:  return APB_DW'(c.image_height);
			REG_BLOCK_WIDTH:   return APB_DW'(c.block_width);
			REG_BLOCK_HEIGHT:  return APB_DW'(c.block_height);
			REG_BLOCKS_ACROSS: return APB_DW'(c.blocks_across);
			REG_BLOCKS_DOWN:   return APB_DW'(c.blocks_down);
			default:           return APB_DW'(c.count_threshold);
		endcase
	endfunction

	// Small grids so that blocks close often; now and then push one register
	// into its odd corner (zero block size, huge or zero grid counts).
	function automatic cfg_t random_cfg();
		cfg_t c;
		int   w, h, bw, bh, ba, bd, thr;
		w  = $urandom_range(1, 24);
		h  = $urandom_range(1, 12);
		ba = $urandom_range(1, 6);
		bd = $urandom_range(1, 4);
		bw = w / ba;
		bh = h / bd;
		case ($urandom_range(0, 5))
			0: bw = $urandom_range(0, w + 3);
			1: bh = $urandom_range(0, h + 3);
			2: ba = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(64, 127);
			3: bd = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(64, 127);
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: thr = 0;
			1: thr = 4194304;
			default: thr = $urandom_range(0, (w * h) / 4 + 1);
		endcase
		c.image_width     = CFG_W'(w);
		c.image_height    = CFG_W'(h);
		c.block_width     = CFG_W'(bw);
		c.block_height    = CFG_W'(bh);
		c.blocks_across   = GRID_CFG_W'(ba);
		c.blocks_down     = GRID_CFG_W'(bd);
		c.count_threshold = COUNT_W'(thr);
		return c;
	endfunction

	// Advance the tracker by one accepted pixel and tell whether it closes a block.
	task automatic track_pixel(input logic [PIX_W-1:0] pv, input logic fs,
			output bit hit, output res_t r);
		int w, h, col, cnt;
		bit row_end, img_end, col_last, row_last, col_end, row_done;
		w = fit_size(shadow_cfg.image_width, MAX_WIDTH);
		h = fit_size(shadow_cfg.image_height, MAX_HEIGHT);
		// A frame start clears position and counts before the pixel is counted.
		if (fs) begin
			pos_x = 0;
			pos_y = 0;
			x_blk = 0;
			y_blk = 0;
			cur_col = 0;
			cur_row = 0;
			foreach (col_counts[i])
				col_counts[i] = 0;
		end
		col = (cur_col > MAX_BLOCKS - 1) ? MAX_BLOCKS - 1 : cur_col;
		cnt = col_counts[col];
		if (pv > WHITE_LEVEL && cnt < int'(COUNT_MAX))
			cnt++;
		col_counts[col] = cnt;

		row_end  = (pos_x + 1 >= w);
		img_end  = (pos_y + 1 >= h);
		col_last = last_index(col, shadow_cfg.blocks_across);
		row_last = last_index(cur_row, shadow_cfg.blocks_down);
		// A zero block size never matches, so such a block runs to the image edge.
		col_end  = row_end || (!col_last && x_blk + 1 == int'(shadow_cfg.block_width));
		row_done = img_end || (!row_last && y_blk + 1 == int'(shadow_cfg.block_height));

		hit = col_end && row_done;
		r = NO_RES;
		if (hit) begin
			r.grid_row   = GRID_W'(cur_row);
			r.grid_col   = GRID_W'(col);
			r.occupied   = (cnt > int'(shadow_cfg.count_threshold));
			r.frame_done = row_end && img_end;
			col_counts[col] = 0;
		end

		if (row_end) begin
			pos_x = 0;
			x_blk = 0;
			cur_col = 0;
			if (img_end) begin
				// Wrap into the next frame without a frame start.
				pos_y = 0;
				y_blk = 0;
				cur_row = 0;
			end else begin
				pos_y++;
				if (row_done) begin
					y_blk = 0;
					cur_row++;
				end else begin
					y_blk++;
				end
			end
		end else begin
			pos_x++;
			if (col_end) begin
				x_blk = 0;
				cur_col = col + 1;
			end else begin
				x_blk++;
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input reg_idx_t idx, output logic [APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Read every register back and compare with what should be stored.
	task automatic verify_regs(input cfg_t c);
		logic [APB_DW-1:0] got;
		reg_idx_t          idx;
		for (int i = int'(REG_IMAGE_WIDTH); i <= int'(REG_COUNT_THRESHOLD); i++) begin
			idx = reg_idx_t'(i);
			apb_read(idx, got);
			if (got !== reg_value(c, idx)) begin
				$display("%0t: register %s expected %0d, got %0d", $time, idx.name(),
					reg_value(c, idx), got);
				mismatches++;
			end
		end
	endtask

	// Drop valid at the next falling edge so no stale request slips in.
	task automatic pix_release();
		@(negedge clk);
		pix_if.valid <= 1'b0;
	endtask

	// Hold until every owed result is back, then give the pipeline time to empty.
	task automatic drain_results();
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Reprogram only with the block idle: nothing owed and nothing in flight.
	task automatic load_cfg(input cfg_t c);
		pix_release();
		drain_results();
		for (int i = int'(REG_IMAGE_WIDTH); i <= int'(REG_COUNT_THRESHOLD); i++)
			apb_write(reg_idx_t'(i), reg_value(c, reg_idx_t'(i)));
		shadow_cfg = c;
		verify_regs(c);
	endtask

	// Offer one pixel request after a random gap; track it once accepted.
	task automatic send_pixel(input logic [PIX_W-1:0] pv, input logic fs,
			output bit hit, output res_t r);
		int gap;
		gap = sender_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			pix_if.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_if.valid       <= 1'b1;
		pix_if.pixel_value <= pv;
		pix_if.frame_start <= fs;
		do @(posedge clk); while (!pix_if.ready);
		track_pixel(pv, fs, hit, r);
	endtask

	task automatic stream_pixel(input logic [PIX_W-1:0] pv, input logic fs);
		bit   hit;
		res_t r;
		send_pixel(pv, fs, hit, r);
		if (hit)
			pending_blocks.push_back(r);
	endtask

	// Raster stream opened by a frame start, with rare frame starts mid-frame.
	// At pause_at the sender holds off until every owed result has come back.
	task automatic run_stream(input int count, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == pause_at) begin
				pix_release();
				while (pending_blocks.size() != 0)
					@(posedge clk);
			end
			stream_pixel(pick_pixel(), (i == 0) || ($urandom_range(0, 49) == 0));
		end
	endtask

	// Result side: accept with random stalls, now and then a long stretch of
	// steady ready.
	initial begin
		int n;
		res_if.ready = 1'b0;
		forever begin
			n = pick_gap();
			repeat (n) begin
				@(negedge clk);
				res_if.ready <= 1'b0;
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
			repeat (n) begin
				@(negedge clk);
				res_if.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_blocks.size() == 0) begin
				$display("%0t: no result expected, got row %0d col %0d occupied %0d done %0d",
					$time, res_if.grid_row, res_if.grid_col, res_if.occupied,
					res_if.frame_done);
				mismatches++;
			end else begin
				oldest_block = pending_blocks.pop_front();
				check_field("grid_row", oldest_block.grid_row, res_if.grid_row);
				check_field("grid_col", oldest_block.grid_col, res_if.grid_col);
				check_field("occupied", oldest_block.occupied, res_if.occupied);
				check_field("frame_done", oldest_block.frame_done, res_if.frame_done);
			end
		end
	end

	// Watchdog: end the run when no request has moved on any port for too long.
	always @(posedge clk) begin
		if (!arst_n || psel || (pix_if.valid && pix_if.ready)
				|| (res_if.valid && res_if.ready)) begin
			idle_run <= 0;
		end else if (idle_run >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	initial begin
		bit   hit;
		res_t r;
		cfg_t c;
		int   random_items;
		int   first_phase;

		// Drive every input to a known value and hold reset.
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		pix_if.valid       = 1'b0;
		pix_if.pixel_value = '0;
		pix_if.frame_start = 1'b0;
		mismatches         = 0;
		sender_quiet       = 1'b0;
		pos_x = 0;
		pos_y = 0;
		x_blk = 0;
		y_blk = 0;
		cur_col = 0;
		cur_row = 0;
		foreach (col_counts[i])
			col_counts[i] = 0;
		shadow_cfg = '{RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, RST_BLOCK_WIDTH, RST_BLOCK_HEIGHT,
			RST_BLOCKS_ACROSS, RST_BLOCKS_DOWN, RST_THRESHOLD};

		// Directed settings:
		// 0: 2x2 image of single-pixel blocks, any white pixel marks a block.
		// 1: grid wider than the image and zero block width, so one block per row.
		// 2: oversized image width and zero grid counts: 1-pixel columns up to the
		//    top column, threshold at 4194304.
		// 3: grid count above the top index, threshold zero, short last column.
		dir_cfgs = '{
			'{12'd2,    12'd2, 12'd1, 12'd1, 7'd2,   7'd2, 23'd0},
			'{12'd3,    12'd2, 12'd0, 12'd1, 7'd4,   7'd4, 23'd1},
			'{12'd4095, 12'd1, 12'd1, 12'd0, 7'd0,   7'd0, 23'd4194304},
			'{12'd5,    12'd1, 12'd2, 12'd2, 7'd127, 7'd1, 23'd0}
		};
		dir_rows = '{
			// Reset settings: 85x85 blocks, nothing closes this early.
			'{ROW_NONE,    0, 8'd255, 1'b1, NO_RES},
			'{ROW_NONE,    0, 8'd0,   1'b0, NO_RES},
			'{ROW_CFG,     0, 8'd0,   1'b0, NO_RES},
			'{ROW_TYPED,   0, 8'd255, 1'b1, '{6'd0, 6'd0, 1'b1, 1'b0}},
			'{ROW_TYPED,   0, 8'd128, 1'b0, '{6'd0, 6'd1, 1'b0, 1'b0}},  // 128 is not white
			'{ROW_TYPED,   0, 8'd129, 1'b0, '{6'd1, 6'd0, 1'b1, 1'b0}},
			'{ROW_TYPED,   0, 8'd0,   1'b0, '{6'd1, 6'd1, 1'b0, 1'b1}},
			'{ROW_TYPED,   0, 8'd200, 1'b0, '{6'd0, 6'd0, 1'b1, 1'b0}},  // wrapped frame
			'{ROW_TYPED,   0, 8'd0,   1'b1, '{6'd0, 6'd0, 1'b0, 1'b0}},  // restart mid-frame
			'{ROW_TYPED,   0, 8'd129, 1'b0, '{6'd0, 6'd1, 1'b1, 1'b0}},
			'{ROW_CFG,     1, 8'd0,   1'b0, NO_RES},
			'{ROW_NONE,    0, 8'd255, 1'b1, NO_RES},
			'{ROW_NONE,    0, 8'd255, 1'b0, NO_RES},
			'{ROW_TYPED,   0, 8'd0,   1'b0, '{6'd0, 6'd0, 1'b1, 1'b0}},
			'{ROW_NONE,    0, 8'd255, 1'b0, NO_RES},
			'{ROW_NONE,    0, 8'd0,   1'b0, NO_RES},
			'{ROW_TYPED,   0, 8'd0,   1'b0, '{6'd1, 6'd0, 1'b0, 1'b1}},
			'{ROW_CFG,     2, 8'd0,   1'b0, NO_RES},
			'{ROW_TYPED,   0, 8'd255, 1'b1, '{6'd0, 6'd0, 1'b0, 1'b0}},
			'{ROW_TYPED,   0, 8'd255, 1'b0, '{6'd0, 6'd1, 1'b0, 1'b0}},
			'{ROW_PREDICT, 0, 8'd77,  1'b0, NO_RES},
			'{ROW_CFG,     3, 8'd0,   1'b0, NO_RES},
			'{ROW_NONE,    0, 8'd129, 1'b1, NO_RES},
			'{ROW_TYPED,   0, 8'd0,   1'b0, '{6'd0, 6'd0, 1'b1, 1'b0}},
			'{ROW_NONE,    0, 8'd0,   1'b0, NO_RES},
			'{ROW_TYPED,   0, 8'd0,   1'b0, '{6'd0, 6'd1, 1'b0, 1'b0}},
			'{ROW_TYPED,   0, 8'd255, 1'b0, '{6'd0, 6'd2, 1'b1, 1'b1}}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Registers must read back their reset values.
		verify_regs(shadow_cfg);

		// Walk the directed table.
		foreach (dir_rows[i]) begin
			case (dir_rows[i].kind)
				ROW_CFG: load_cfg(dir_cfgs[dir_rows[i].arg]);
				ROW_TYPED: begin
					send_pixel(dir_rows[i].pix, dir_rows[i].fs, hit, r);
					pending_blocks.push_back(dir_rows[i].want);
				end
				ROW_NONE: send_pixel(dir_rows[i].pix, dir_rows[i].fs, hit, r);
				default: stream_pixel(dir_rows[i].pix, dir_rows[i].fs);
			endcase
		end

		// Smallest settings: every pixel is a whole frame.
		c = '{12'd1, 12'd1, 12'd1, 12'd1, 7'd1, 7'd1, 23'd0};
		load_cfg(c);
		run_stream(40, -1);

		// One-row frame with 64 block columns of two pixels, the last one closing it.
		c = '{12'd128, 12'd1, 12'd2, 12'd2048, 7'd64, 7'd64, 23'd1};
		load_cfg(c);
		run_stream(128, -1);

		// Oversized height on a one-pixel-wide image: tall blocks close rarely.
		c = '{12'd1, 12'd4095, 12'd4095, 12'd40, 7'd127, 7'd3, 23'd20};
		load_cfg(c);
		run_stream(200, -1);

		// Random settings, each phase a raster stream with random content.
		random_items = 0;
		first_phase = 1;
		while (random_items < RANDOM_ITEMS) begin
			c = random_cfg();
			load_cfg(c);
			sender_quiet = ($urandom_range(0, 3) == 0);
			r.grid_row = '0;
			hit = 0;
			begin
				int n;
				n = $urandom_range(40, 120);
				run_stream(n, first_phase ? n / 2 : -1);
				random_items += n;
			end
			first_phase = 0;
		end

		// Stop offering pixels, collect what is owed, then watch a little longer
		// for stray results.
		pix_release();
		while (pending_blocks.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_blocks.size() != 0)
			mismatches++;

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
